@@ src/glnw_pkg.sv @@
// glnw_pkg: shared types, constants, saturating helpers and ALU request
// builders for the Gauss-Legendre node/weight generator. No dependencies.
package glnw_pkg;

	localparam int unsigned NODE_IDX_W  = 6;
	localparam int unsigned DEF_MAX_POINTS = 64;
	localparam int unsigned IO_W        = 48;
	localparam int unsigned PC_W        = 7;
	localparam int unsigned TOL_W       = 32;
	localparam int unsigned ITER_W      = 4;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned DIV_W       = 13;
	localparam int unsigned SH_W        = 7;
	localparam int unsigned SERIES_TERMS = 14;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 2'd2;

	localparam logic [PC_W-1:0]   RST_POINT_COUNT = 7'd8;
	localparam logic [TOL_W-1:0]  RST_TOLERANCE   = 32'd115292;
	localparam logic [ITER_W-1:0] RST_MAX_ITER    = 4'd15;

	localparam logic signed [63:0] ONE_Q60     = 64'sh1000_0000_0000_0000;
	localparam logic signed [63:0] PI_Q60      = 64'sh3243_F6A8_885A_308D;
	localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921_FB54_442D_1846;
	localparam logic signed [63:0] S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN     = 64'sh8000_0000_0000_0000;

	// first quotient bit examined by the divider for each kind of division
	localparam logic [SH_W-1:0] MULDIV_TOP = 7'd79;
	localparam logic [SH_W-1:0] SDIV_TOP   = 7'd107;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_MULDIV,
		OP_SDIV
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [DIV_W-1:0]   d;
		logic [SH_W-1:0]    sh;
		logic signed [63:0] offs;
	} alu_req_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic signed [63:0] sadd64(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub64(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} - {y[63], y};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssat62(input logic signed [63:0] v);
		if (v[63:61] != {3{v[63]}}) return v[63] ? -64'sh2000_0000_0000_0000
			: 64'sh1FFF_FFFF_FFFF_FFFF;
		return v;
	endfunction

	function automatic logic [IO_W-1:0] ssat48(input logic signed [63:0] v);
		if (v[63:47] != {17{v[63]}}) return v[63] ? {1'b1, {(IO_W-1){1'b0}}}
			: {1'b0, {(IO_W-1){1'b1}}};
		return v[IO_W-1:0];
	endfunction

	function automatic alu_req_t mk_mul(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic [SH_W-1:0] sh);
		alu_req_t r;
		r.op = OP_MUL; r.a = a; r.b = b; r.d = '0; r.sh = sh; r.offs = '0;
		return r;
	endfunction

	function automatic alu_req_t mk_map(input logic signed [63:0] dlt,
			input logic signed [63:0] y, input logic signed [63:0] s);
		alu_req_t r;
		r.op = OP_MUL; r.a = dlt; r.b = y; r.d = '0; r.sh = 7'd61; r.offs = s;
		return r;
	endfunction

	function automatic alu_req_t mk_muldiv(input logic signed [63:0] a,
			input logic [63:0] m, input logic [DIV_W-1:0] d);
		alu_req_t r;
		r.op = OP_MULDIV; r.a = a; r.b = m; r.d = d; r.sh = '0; r.offs = '0;
		return r;
	endfunction

	function automatic alu_req_t mk_sdiv(input logic signed [63:0] num,
			input logic signed [63:0] den, input logic [SH_W-1:0] sh);
		alu_req_t r;
		r.op = OP_SDIV; r.a = num; r.b = den; r.d = '0; r.sh = sh; r.offs = '0;
		return r;
	endfunction

endpackage

@@ src/glnw_cfg_if.sv @@
// glnw_cfg_if: register write channel of the node/weight generator.
// Depends on glnw_pkg for widths.
interface glnw_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [glnw_pkg::CFG_IDX_W-1:0]     index;
	logic [glnw_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/glnw_req_if.sv @@
// glnw_req_if: request channel carrying the interval endpoints.
// Depends on glnw_pkg for widths.
interface glnw_req_if;
	logic                               valid;
	logic                               ready;
	logic signed [glnw_pkg::IO_W-1:0]   interval_low;
	logic signed [glnw_pkg::IO_W-1:0]   interval_high;
	modport source (output valid, interval_low, interval_high, input ready);
	modport sink (input valid, interval_low, interval_high, output ready);
endinterface

@@ src/glnw_res_if.sv @@
// glnw_res_if: result channel, one item per quadrature node.
// Depends on glnw_pkg for widths.
interface glnw_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [glnw_pkg::IO_W-1:0]     node;
	logic signed [glnw_pkg::IO_W-1:0]     weight;
	logic [glnw_pkg::NODE_IDX_W-1:0]      node_index;
	logic                                 not_converged;
	logic                                 last;
	modport source (output valid, node, weight, node_index, not_converged, last,
		input ready);
	modport sink (input valid, node, weight, node_index, not_converged, last,
		output ready);
endinterface

@@ src/gauss_legendre_nodes_weights_unit.sv @@
// Gauss-Legendre node and weight generator. Each request item carries an
// interval [low, high] in Q8.40; the unit returns point_count result items,
// at most MAX_POINTS (node, weight, index, not_converged, last), node 0
// nearest to high. All work runs on one shared multiply/divide unit, whose
// divides produce one quotient bit a cycle. The run time of an item is set
// by the bit-serial divides in the sine and cosine series and in the
// Legendre recurrence; each result item is held until result.ready takes it.
// request.ready stays low until the last result has been taken. Depends on
// glnw_pkg, the channel interfaces, glnw_alu and glnw_seq.
module gauss_legendre_nodes_weights_unit #(
	parameter int unsigned MAX_POINTS = glnw_pkg::DEF_MAX_POINTS
) (
	input  logic       clk,
	input  logic       arst_n,
	glnw_cfg_if.sink   cfg,
	glnw_req_if.sink   request,
	glnw_res_if.source result
);
	import glnw_pkg::*;

	logic [PC_W-1:0]    point_count_q;
	logic [TOL_W-1:0]   tolerance_q;
	logic [ITER_W-1:0]  max_iter_q;
	logic               idle, go, done, start;
	alu_req_t           req;
	logic signed [63:0] res;

	assign cfg.ready     = 1'b1;
	assign request.ready = idle;
	assign start         = request.valid && idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= RST_POINT_COUNT;
			tolerance_q   <= RST_TOLERANCE;
			max_iter_q    <= RST_MAX_ITER;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_POINT_COUNT: point_count_q <= cfg.data[PC_W-1:0];
				REG_TOLERANCE:   tolerance_q   <= cfg.data[TOL_W-1:0];
				REG_MAX_ITER:    max_iter_q    <= cfg.data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	glnw_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	glnw_seq #(
		.MAX_POINTS (MAX_POINTS)
	) u_seq (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.idle               (idle),
		.a_in               (request.interval_low),
		.b_in               (request.interval_high),
		.point_count        (point_count_q),
		.converge_tolerance (tolerance_q),
		.max_iterations     (max_iter_q),
		.go                 (go),
		.req                (req),
		.done               (done),
		.res                (res),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.out_node           (result.node),
		.out_weight         (result.weight),
		.out_index          (result.node_index),
		.out_nc             (result.not_converged),
		.out_last           (result.last)
	);

endmodule

@@ src/glnw_alu.sv @@
// glnw_alu: shared multi-cycle arithmetic unit: 64x64 multiply from four
// 32x32 partial products, rounding shift with saturation, 1-bit-a-cycle divide.
// Depends on glnw_pkg.
module glnw_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  glnw_pkg::alu_req_t req,
	output logic               done,
	output logic signed [63:0] res
);
	import glnw_pkg::*;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_FIX,
		A_ROUND,
		A_DIV,
		A_QOUT
	} astate_t;

	astate_t            state_q;
	alu_op_t            op_q;
	logic [SH_W-1:0]    sh_q;
	logic signed [63:0] offs_q;
	logic               neg_q;
	logic [63:0]        ma_q, mb_q, d_q, r_q;
	logic [127:0]       acc_q, num_q, q_q;
	logic [1:0]         cnt_q;
	logic [SH_W-1:0]    bit_q;

	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [1:0]   pos;
	logic [127:0] acc_sum, rnd_add, rnd_v;
	logic [64:0]  r65, rsub;
	logic         ge;

	function automatic logic signed [63:0] sat128(input logic [127:0] v);
		if (v[127:64] != {64{v[63]}}) return v[127] ? S64_MIN : S64_MAX;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] from_mag(input logic [127:0] q,
			input logic neg);
		if (q[127:63] != '0) return neg ? S64_MIN : S64_MAX;
		return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	always_comb begin
		pa      = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb      = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp      = pa * pb;
		pos     = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		acc_sum = acc_q + ({64'b0, pp} << {pos, 5'b0});
		// round to nearest, ties up, then arithmetic shift
		rnd_add = (sh_q == '0) ? acc_q : acc_q + (128'd1 << (sh_q - 7'd1));
		rnd_v   = $signed(rnd_add) >>> sh_q;
		r65     = {r_q, num_q[bit_q]};
		rsub    = r65 - {1'b0, d_q};
		ge      = r65 >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (go) begin
						op_q   <= req.op;
						sh_q   <= req.sh;
						offs_q <= req.offs;
						acc_q  <= '0;
						cnt_q  <= '0;
						q_q    <= '0;
						r_q    <= '0;
						ma_q   <= mag64(req.a);
						case (req.op)
							OP_MUL: begin
								mb_q    <= mag64(req.b);
								neg_q   <= req.a[63] ^ req.b[63];
								state_q <= A_MUL;
							end
							OP_MULDIV: begin
								mb_q    <= req.b;
								neg_q   <= req.a[63];
								d_q     <= {{(64-DIV_W){1'b0}}, req.d};
								state_q <= A_MUL;
							end
							default: begin
								neg_q <= req.a[63] ^ req.b[63];
								d_q   <= mag64(req.b);
								num_q <= {64'b0, mag64(req.a)} << req.sh;
								bit_q <= SDIV_TOP;
								if (req.b == '0) begin
									// zero divisor saturates by the dividend's sign; a zero dividend gives zero
									res     <= req.a[63] ? S64_MIN :
										((req.a == '0) ? 64'sd0 : S64_MAX);
									done    <= 1'b1;
									state_q <= A_IDLE;
								end else begin
									state_q <= A_DIV;
								end
							end
						endcase
					end
				end
				A_MUL: begin
					acc_q <= acc_sum;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (op_q == OP_MUL) begin
							state_q <= A_FIX;
						end else begin
							num_q   <= acc_sum;
							bit_q   <= MULDIV_TOP;
							state_q <= A_DIV;
						end
					end
				end
				A_FIX: begin
					acc_q   <= (neg_q ? (~acc_q + 128'd1) : acc_q)
						+ ({{64{offs_q[63]}}, offs_q} << 60);
					state_q <= A_ROUND;
				end
				A_ROUND: begin
					res     <= sat128(rnd_v);
					done    <= 1'b1;
					state_q <= A_IDLE;
				end
				A_DIV: begin
					r_q <= ge ? rsub[63:0] : r65[63:0];
					q_q <= {q_q[126:0], ge};
					if (bit_q == '0) state_q <= A_QOUT;
					else bit_q <= bit_q - 7'd1;
				end
				A_QOUT: begin
					res     <= from_mag(q_q, neg_q);
					done    <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

@@ src/glnw_seq.sv @@
// glnw_seq: sequencer that runs the initial guess, the Newton passes and the
// node/weight mapping on glnw_alu, with the estimate and derivative stores.
// Depends on glnw_pkg.
module glnw_seq #(
	parameter int unsigned MAX_POINTS = glnw_pkg::DEF_MAX_POINTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              idle,
	input  logic signed [glnw_pkg::IO_W-1:0]  a_in,
	input  logic signed [glnw_pkg::IO_W-1:0]  b_in,
	input  logic [glnw_pkg::PC_W-1:0]         point_count,
	input  logic [glnw_pkg::TOL_W-1:0]        converge_tolerance,
	input  logic [glnw_pkg::ITER_W-1:0]       max_iterations,
	output logic                              go,
	output glnw_pkg::alu_req_t                req,
	input  logic                              done,
	input  logic signed [63:0]                res,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [glnw_pkg::IO_W-1:0]         out_node,
	output logic [glnw_pkg::IO_W-1:0]         out_weight,
	output logic [glnw_pkg::NODE_IDX_W-1:0]   out_index,
	output logic                              out_nc,
	output logic                              out_last
);
	import glnw_pkg::*;

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_COEF, S_P1, S_CX2, S_SMUL, S_SDV, S_P2, S_SX2, S_CS,
		S_RD, S_LD, S_RT, S_RDV, S_NUM, S_DEN, S_QD, S_LPM, S_STP, S_UPD,
		S_TW, S_ORD, S_OLD, S_ONODE, S_ODEN, S_OD1, S_OD2, S_OW, S_OWAIT
	} state_t;

	state_t                 state_q;
	logic                   pend_q;
	logic [PC_W-1:0]        n_q;
	logic [ITER_W-1:0]      limit_q, iter_q;
	logic [NODE_IDX_W-1:0]  i_q;
	logic [PC_W-1:0]        k_q;
	logic [4:0]             j_q;
	logic [3:0]             cnt_q;
	logic                   flip_q, sneg_q, ser_sin_q;
	logic signed [63:0]     s_q, dlt_q, coef_q, c_q, r_q, x2_q, sum_q, term_q;
	logic signed [63:0]     y_q, l_q, lm1_q, t_q, num_q, den_q, lp_q, step_q, tw_q, dd_q;
	logic [63:0]            maxd_q;

	logic signed [61:0]     est_mem [MAX_POINTS];
	logic signed [63:0]     lpd_mem [MAX_POINTS];
	logic signed [61:0]     est_rd_q;
	logic signed [63:0]     lpd_rd_q;
	logic                   est_we, lpd_we;
	logic signed [61:0]     est_wd;
	logic [AW-1:0]          addr;

	logic                   op_st;
	alu_req_t               nreq;
	logic [DIV_W-1:0]       n13, np1;
	logic signed [8:0]      m9;
	logic [8:0]             absm;
	logic signed [63:0]     p2r, nt, snew, yn, diff, cs_est;
	logic [63:0]            dmag, maxd_new;
	logic [ITER_W-1:0]      iter_n;
	logic [PC_W-1:0]        n_clamp;
	logic                   last_i;

	assign idle   = (state_q == S_IDLE);
	assign addr   = i_q[AW-1:0];
	assign last_i = ({1'b0, i_q} == n_q - 7'd1);

	always_comb begin
		n13      = {{(DIV_W-PC_W){1'b0}}, n_q};
		np1      = n13 + 13'd1;
		m9       = $signed({2'b0, i_q, 1'b1}) - $signed({2'b0, n_q});
		absm     = m9[8] ? 9'(-m9) : 9'(m9);
		p2r      = res[63] ? ssub64(64'sd0, res) : res;
		nt       = ssub64(64'sd0, res);
		snew     = sadd64(sum_q, nt);
		cs_est   = ssat62(sadd64(c_q, res));
		yn       = ssat62(ssub64(y_q, step_q));
		diff     = yn - y_q;
		dmag     = mag64(diff);
		maxd_new = (dmag > maxd_q) ? dmag : maxd_q;
		iter_n   = iter_q + 4'd1;
		n_clamp  = (point_count > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : point_count;
	end

	// request for the current arithmetic step
	always_comb begin
		op_st = 1'b1;
		nreq  = mk_mul(y_q, y_q, 7'd60);
		unique case (state_q)
			S_COEF:  nreq = mk_muldiv(ONE_Q60, 64'd27, n13 * 13'd100);
			S_P1:    nreq = mk_muldiv(PI_Q60, {57'b0, i_q, 1'b1}, n13 << 1);
			S_CX2,
			S_SX2:   nreq = mk_mul(r_q, r_q, 7'd60);
			S_SMUL:  nreq = mk_mul(term_q, x2_q, 7'd60);
			S_SDV:   nreq = mk_muldiv(term_q, 64'd1,
				13'({8'b0, j_q} * ({8'b0, j_q} + 13'd1)));
			S_P2:    nreq = mk_muldiv(m9[8] ? -PI_Q60 : PI_Q60, {55'b0, absm}, np1);
			S_CS:    nreq = mk_mul(coef_q, sum_q, 7'd60);
			S_RT:    nreq = mk_mul(y_q, l_q, 7'd60);
			S_RDV:   nreq = mk_muldiv(ssub64(t_q, lm1_q), {57'b0, k_q - 7'd1},
				{{(DIV_W-PC_W){1'b0}}, k_q});
			S_NUM:   nreq = mk_mul(y_q, l_q, 7'd60);
			S_DEN,
			S_ODEN:  nreq = mk_mul(y_q, y_q, 7'd60);
			S_QD:    nreq = mk_sdiv(num_q, den_q, 7'd44);
			S_LPM:   nreq = mk_mul(num_q, {51'b0, np1}, 7'd0);
			S_STP:   nreq = mk_sdiv(l_q, lp_q, 7'd44);
			S_TW:    nreq = mk_muldiv(dlt_q, {51'b0, np1 * np1}, n13 * n13);
			S_ONODE: nreq = mk_map(dlt_q, y_q, s_q);
			S_OD1:   nreq = mk_mul(den_q, lp_q, 7'd60);
			S_OD2:   nreq = mk_mul(dd_q, lp_q, 7'd44);
			S_OW:    nreq = mk_sdiv(tw_q, dd_q, 7'd44);
			default: op_st = 1'b0;
		endcase
	end

	always_comb begin
		est_we = 1'b0;
		lpd_we = 1'b0;
		est_wd = yn[61:0];
		if (state_q == S_CS && done) begin
			est_we = 1'b1;
			est_wd = cs_est[61:0];
		end else if (state_q == S_UPD) begin
			est_we = 1'b1;
			lpd_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (est_we) est_mem[addr] <= est_wd;
		if (lpd_we) lpd_mem[addr] <= lp_q;
		est_rd_q <= est_mem[addr];
		lpd_rd_q <= lpd_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= 1'b0;
			go        <= 1'b0;
			out_valid <= 1'b0;
			iter_q    <= '0;
		end else begin
			go <= 1'b0;
			if (op_st && !pend_q) begin
				req    <= nreq;
				go     <= 1'b1;
				pend_q <= 1'b1;
			end else if (done) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && point_count != '0) begin
						n_q     <= n_clamp;
						limit_q <= (max_iterations == '0) ? 4'd1 : max_iterations;
						s_q     <= 64'(a_in) + 64'(b_in);
						dlt_q   <= 64'(b_in) - 64'(a_in);
						i_q     <= '0;
						state_q <= S_COEF;
					end
				end
				S_COEF: if (done) begin
					coef_q  <= res;
					state_q <= S_P1;
				end
				S_P1: if (done) begin
					// fold into the first quadrant
					flip_q  <= res > HALF_PI_Q60;
					r_q     <= (res > HALF_PI_Q60) ? PI_Q60 - res : res;
					state_q <= S_CX2;
				end
				S_CX2: if (done) begin
					x2_q      <= res;
					sum_q     <= ONE_Q60;
					term_q    <= ONE_Q60;
					j_q       <= 5'd1;
					cnt_q     <= '0;
					ser_sin_q <= 1'b0;
					state_q   <= S_SMUL;
				end
				S_SMUL: if (done) begin
					term_q  <= res;
					state_q <= S_SDV;
				end
				S_SDV: if (done) begin
					term_q <= nt;
					sum_q  <= snew;
					j_q    <= j_q + 5'd2;
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'(SERIES_TERMS - 1)) begin
						if (ser_sin_q) begin
							sum_q   <= sneg_q ? ssub64(64'sd0, snew) : snew;
							state_q <= S_CS;
						end else begin
							c_q     <= flip_q ? ssub64(64'sd0, snew) : snew;
							state_q <= S_P2;
						end
					end else begin
						state_q <= S_SMUL;
					end
				end
				S_P2: if (done) begin
					sneg_q  <= res[63];
					r_q     <= (p2r > HALF_PI_Q60) ? ssub64(PI_Q60, p2r) : p2r;
					state_q <= S_SX2;
				end
				S_SX2: if (done) begin
					x2_q      <= res;
					sum_q     <= r_q;
					term_q    <= r_q;
					j_q       <= 5'd2;
					cnt_q     <= '0;
					ser_sin_q <= 1'b1;
					state_q   <= S_SMUL;
				end
				S_CS: if (done) begin
					if (last_i) begin
						i_q     <= '0;
						iter_q  <= '0;
						maxd_q  <= '0;
						state_q <= S_RD;
					end else begin
						i_q     <= i_q + 6'd1;
						state_q <= S_P1;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					y_q     <= 64'(est_rd_q);
					l_q     <= 64'(est_rd_q);
					lm1_q   <= ONE_Q60;
					k_q     <= 7'd2;
					state_q <= (n_q < 7'd2) ? S_NUM : S_RT;
				end
				S_RT: if (done) begin
					t_q     <= res;
					state_q <= S_RDV;
				end
				S_RDV: if (done) begin
					lm1_q <= l_q;
					l_q   <= sadd64(t_q, res);
					if (k_q == n_q) state_q <= S_NUM;
					else begin
						k_q     <= k_q + 7'd1;
						state_q <= S_RT;
					end
				end
				S_NUM: if (done) begin
					num_q   <= ssub64(lm1_q, res);
					state_q <= S_DEN;
				end
				S_DEN: if (done) begin
					den_q   <= ssub64(ONE_Q60, res);
					state_q <= S_QD;
				end
				S_QD: if (done) begin
					num_q   <= res;
					state_q <= S_LPM;
				end
				S_LPM: if (done) begin
					lp_q <= res;
					if (res == '0) begin
						step_q  <= '0;
						state_q <= S_UPD;
					end else begin
						state_q <= S_STP;
					end
				end
				S_STP: if (done) begin
					step_q  <= res;
					state_q <= S_UPD;
				end
				S_UPD: begin
					maxd_q <= maxd_new;
					if (last_i) begin
						iter_q <= iter_n;
						i_q    <= '0;
						if (maxd_new > {32'b0, converge_tolerance} && iter_n < limit_q) begin
							maxd_q  <= '0;
							state_q <= S_RD;
						end else begin
							out_nc  <= maxd_new > {32'b0, converge_tolerance};
							state_q <= S_TW;
						end
					end else begin
						i_q     <= i_q + 6'd1;
						state_q <= S_RD;
					end
				end
				S_TW: if (done) begin
					tw_q    <= res;
					state_q <= S_ORD;
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					y_q     <= 64'(est_rd_q);
					lp_q    <= lpd_rd_q;
					state_q <= S_ONODE;
				end
				S_ONODE: if (done) begin
					out_node <= ssat48(res);
					state_q  <= S_ODEN;
				end
				S_ODEN: if (done) begin
					den_q   <= ssub64(ONE_Q60, res);
					state_q <= S_OD1;
				end
				S_OD1: if (done) begin
					dd_q    <= res;
					state_q <= S_OD2;
				end
				S_OD2: if (done) begin
					dd_q    <= res;
					state_q <= S_OW;
				end
				S_OW: if (done) begin
					out_weight <= ssat48(res);
					out_index  <= i_q;
					out_last   <= last_i;
					out_valid  <= 1'b1;
					state_q    <= S_OWAIT;
				end
				S_OWAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (out_last) state_q <= S_IDLE;
						else begin
							i_q     <= i_q + 6'd1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
